/* rtl/scs_pkg.sv */
// Shared widths, types, codes and control structs for the split count selector.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package scs_pkg;

   // field and register widths
   localparam int WORK_W     = 24;
   localparam int COLS_W     = 13;
   localparam int CU_W       = 11;
   localparam int LIMIT_W    = 8;
   localparam int SPLIT_W    = 8;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;

   // scan bounds
   localparam int SPLIT_CAP  = 128;
   localparam int S_W        = $clog2(SPLIT_CAP + 1);
   localparam int IDX_W      = $clog2(SPLIT_CAP);

   // On the scan path 5*work < 4*units, so work < units fits in CU_W bits.
   localparam int N_W        = CU_W + S_W;
   localparam int P_W        = 2 * N_W;
   localparam int SCALED_W   = P_W + 5;
   localparam int FILL_W     = WORK_W + 3;

   // column divider: 4 quotient bits per cycle
   localparam int DIVD_W     = 16;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = DIVD_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int REM_W      = S_W + 1;

   typedef logic [WORK_W-1:0]    work_type;
   typedef logic [COLS_W-1:0]    cols_type;
   typedef logic [CU_W-1:0]      cu_type;
   typedef logic [LIMIT_W-1:0]   limit_type;
   typedef logic [SPLIT_W-1:0]   split_type;
   typedef logic [DATA_W-1:0]    word_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [S_W-1:0]       s_type;
   typedef logic [N_W-1:0]       n_type;
   typedef logic [P_W-1:0]       prod_type;
   typedef logic [SCALED_W-1:0]  scaled_type;
   typedef logic [FILL_W-1:0]    fill_type;
   typedef logic [DIVD_W-1:0]    divd_type;
   typedef logic [REM_W-1:0]     rem_type;
   typedef logic [DIV_CNT_W-1:0] div_cnt_type;

   localparam cu_type    CU_RESET    = cu_type'(128);
   localparam limit_type LIMIT_RESET = limit_type'(128);

   typedef enum logic [0:0] {
      REG_COMPUTE_UNITS = 1'b0,
      REG_SPLIT_LIMIT   = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_P1_STEP,
      ST_P1_LAUNCH,
      ST_P1_WAIT,
      ST_P1_RESOLVE,
      ST_P2_BEGIN,
      ST_P2_STEP,
      ST_P2_MUL,
      ST_P2_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic begin_pass;
      logic step;
      logic div_start;
      logic mul;
      logic resolve;
      logic update_best;
      logic mem_read;
      logic res_one;
      logic res_s;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic div_done;
      logic last;
      logic elig;
      logic better;
      logic good;
   } status_type;

endpackage

/* rtl/scs_divider.sv */
// Multi-cycle restoring divider for ceil(column_blocks / s).
// Depends on scs_pkg; DIV_BITS quotient bits are retired per cycle.

module scs_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  scs_pkg::divd_type dividend,
   input  scs_pkg::s_type    divisor,
   output scs_pkg::cols_type quotient,
   output logic              done
);

   logic                     busy_ff;
   logic                     done_ff;
   scs_pkg::div_cnt_type     cnt_ff;
   scs_pkg::rem_type         rem_ff;
   scs_pkg::divd_type        quo_ff;
   scs_pkg::s_type           div_ff;
   scs_pkg::rem_type         rem_in;
   scs_pkg::divd_type        quo_in;

   always_comb begin
      logic bit_in;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < scs_pkg::DIV_BITS; i++) begin
         bit_in = quo_in[scs_pkg::DIVD_W-1];
         quo_in = {quo_in[scs_pkg::DIVD_W-2:0], 1'b0};
         rem_in = {rem_in[scs_pkg::REM_W-2:0], bit_in};
         if (rem_in >= scs_pkg::rem_type'(div_ff)) begin
            rem_in    = rem_in - scs_pkg::rem_type'(div_ff);
            quo_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + scs_pkg::div_cnt_type'(1);
            if (cnt_ff == scs_pkg::div_cnt_type'(scs_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff[scs_pkg::COLS_W-1:0];
   assign done     = done_ff;

endmodule

/* rtl/scs_datapath.sv */
// Datapath: operand capture, running wave count, cross products, eligibility store.
// Depends on scs_pkg and scs_divider; driven by scs_ctrl through cmd_type/status_type.

module scs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  scs_pkg::cmd_type    cmd,
   output scs_pkg::status_type status,
   input  scs_pkg::work_type   req_work_blocks,
   input  scs_pkg::cols_type   req_column_blocks,
   input  scs_pkg::cu_type     cfg_compute_units,
   input  scs_pkg::limit_type  cfg_split_limit,
   output scs_pkg::split_type  split_count
);

   scs_pkg::work_type    work_ff;
   scs_pkg::cols_type    cols_ff;
   scs_pkg::s_type       lim_ff;
   logic                 quick_ff;
   scs_pkg::s_type       s_ff;
   scs_pkg::n_type       n_ff;
   scs_pkg::n_type       q_ff;
   scs_pkg::cu_type      r_ff;
   scs_pkg::n_type       k_ff;
   scs_pkg::cols_type    prevc_ff;
   scs_pkg::n_type       best_n_ff;
   scs_pkg::n_type       best_k_ff;
   scs_pkg::prod_type    pa_ff;
   scs_pkg::prod_type    pb_ff;
   logic                 rd_ff;
   scs_pkg::split_type   res_ff;
   logic                 elig_mem [scs_pkg::SPLIT_CAP];

   scs_pkg::cols_type    lim_cols;
   scs_pkg::fill_type    five_w;
   scs_pkg::fill_type    four_u;
   logic                 quick_in;
   logic [scs_pkg::CU_W:0] sum_r;
   logic [scs_pkg::CU_W:0] diff_r;
   logic                 wrap;
   scs_pkg::cu_type      r_in;
   scs_pkg::n_type       q_in;
   scs_pkg::n_type       k_in;
   scs_pkg::n_type       n_in;
   scs_pkg::s_type       s_m1;
   scs_pkg::cols_type    div_quo;
   logic                 div_done;
   scs_pkg::divd_type    div_dividend;
   logic                 elig_now;
   scs_pkg::scaled_type  pa_x20;
   scs_pkg::scaled_type  pb_x17;

   // scan bound and early-out test, taken from the request ports and configuration at load
   always_comb begin
      lim_cols = req_column_blocks;
      if (scs_pkg::cols_type'(cfg_compute_units) < lim_cols)
         lim_cols = scs_pkg::cols_type'(cfg_compute_units);
      if (scs_pkg::cols_type'(cfg_split_limit) < lim_cols)
         lim_cols = scs_pkg::cols_type'(cfg_split_limit);
      if (scs_pkg::cols_type'(scs_pkg::SPLIT_CAP) < lim_cols)
         lim_cols = scs_pkg::cols_type'(scs_pkg::SPLIT_CAP);
      five_w   = scs_pkg::fill_type'({req_work_blocks, 2'b00})
               + scs_pkg::fill_type'(req_work_blocks);
      four_u   = scs_pkg::fill_type'({cfg_compute_units, 2'b00});
      quick_in = (five_w >= four_u) || (req_work_blocks == '0) || (lim_cols == '0);
   end

   // n = work*s and k = ceil(n/units), advanced by one s; work < units here
   always_comb begin
      sum_r  = {1'b0, r_ff} + {1'b0, work_ff[scs_pkg::CU_W-1:0]};
      diff_r = sum_r - {1'b0, cfg_compute_units};
      wrap   = (sum_r >= {1'b0, cfg_compute_units});
      r_in   = wrap ? diff_r[scs_pkg::CU_W-1:0] : sum_r[scs_pkg::CU_W-1:0];
      q_in   = q_ff + scs_pkg::n_type'(wrap);
      k_in   = q_in + scs_pkg::n_type'(r_in != '0);
      n_in   = n_ff + scs_pkg::n_type'(work_ff[scs_pkg::CU_W-1:0]);
      s_m1   = s_ff - scs_pkg::s_type'(1);
   end

   assign div_dividend = scs_pkg::divd_type'(cols_ff) + scs_pkg::divd_type'(s_ff)
                       - scs_pkg::divd_type'(1);

   scs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (s_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign elig_now = (s_ff == scs_pkg::s_type'(1)) || (div_quo != prevc_ff);
   assign pa_x20   = scs_pkg::scaled_type'({pa_ff, 4'b0000})
                   + scs_pkg::scaled_type'({pa_ff, 2'b00});
   assign pb_x17   = scs_pkg::scaled_type'({pb_ff, 4'b0000})
                   + scs_pkg::scaled_type'(pb_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff   <= req_work_blocks;
         cols_ff   <= req_column_blocks;
         lim_ff    <= lim_cols[scs_pkg::S_W-1:0];
         quick_ff  <= quick_in;
         best_n_ff <= '0;
         best_k_ff <= scs_pkg::n_type'(1);
      end else if (cmd.update_best) begin
         best_n_ff <= n_ff;
         best_k_ff <= k_ff;
      end

      if (cmd.load || cmd.begin_pass) begin
         s_ff <= '0;
         n_ff <= '0;
         q_ff <= '0;
         r_ff <= '0;
         k_ff <= '0;
      end else if (cmd.step) begin
         s_ff <= s_ff + scs_pkg::s_type'(1);
         n_ff <= n_in;
         q_ff <= q_in;
         r_ff <= r_in;
         k_ff <= k_in;
      end

      if (cmd.mul) begin
         pa_ff <= scs_pkg::prod_type'(n_ff) * scs_pkg::prod_type'(best_k_ff);
         pb_ff <= scs_pkg::prod_type'(best_n_ff) * scs_pkg::prod_type'(k_ff);
      end

      if (cmd.resolve)
         prevc_ff <= div_quo;

      if (cmd.res_one)
         res_ff <= scs_pkg::split_type'(1);
      else if (cmd.res_s)
         res_ff <= scs_pkg::split_type'(s_ff);
   end

   // eligibility bits, one per split count, written in the first pass
   always_ff @(posedge clock) begin
      if (cmd.resolve)
         elig_mem[s_m1[scs_pkg::IDX_W-1:0]] <= elig_now;
      if (cmd.mem_read)
         rd_ff <= elig_mem[s_ff[scs_pkg::IDX_W-1:0]];
   end

   assign status.quick    = quick_ff;
   assign status.div_done = div_done;
   assign status.last     = (s_ff == lim_ff);
   assign status.elig     = elig_now;
   assign status.better   = (pa_ff > pb_ff);
   assign status.good     = rd_ff && (pa_x20 >= pb_x17);

   assign split_count = res_ff;

endmodule

/* rtl/scs_ctrl.sv */
// Sequencer for the two scan passes over split counts.
// Depends on scs_pkg; commands scs_datapath and reads its status.

module scs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  scs_pkg::status_type status,
   output scs_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   scs_pkg::state_type state_ff;
   scs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= scs_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         scs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = scs_pkg::ST_CHECK;
            end
         end
         scs_pkg::ST_CHECK: begin
            if (status.quick) begin
               cmd.res_one = 1'b1;
               state_in    = scs_pkg::ST_DONE;
            end else begin
               state_in = scs_pkg::ST_P1_STEP;
            end
         end
         scs_pkg::ST_P1_STEP: begin
            cmd.step = 1'b1;
            state_in = scs_pkg::ST_P1_LAUNCH;
         end
         scs_pkg::ST_P1_LAUNCH: begin
            cmd.div_start = 1'b1;
            cmd.mul       = 1'b1;
            state_in      = scs_pkg::ST_P1_WAIT;
         end
         scs_pkg::ST_P1_WAIT: begin
            if (status.div_done)
               state_in = scs_pkg::ST_P1_RESOLVE;
         end
         scs_pkg::ST_P1_RESOLVE: begin
            cmd.resolve     = 1'b1;
            cmd.update_best = status.elig && status.better;
            state_in = status.last ? scs_pkg::ST_P2_BEGIN : scs_pkg::ST_P1_STEP;
         end
         scs_pkg::ST_P2_BEGIN: begin
            cmd.begin_pass = 1'b1;
            state_in       = scs_pkg::ST_P2_STEP;
         end
         scs_pkg::ST_P2_STEP: begin
            cmd.step     = 1'b1;
            cmd.mem_read = 1'b1;
            state_in     = scs_pkg::ST_P2_MUL;
         end
         scs_pkg::ST_P2_MUL: begin
            cmd.mul  = 1'b1;
            state_in = scs_pkg::ST_P2_CHECK;
         end
         scs_pkg::ST_P2_CHECK: begin
            if (status.good) begin
               cmd.res_s = 1'b1;
               state_in  = scs_pkg::ST_DONE;
            end else if (status.last) begin
               cmd.res_one = 1'b1;
               state_in    = scs_pkg::ST_DONE;
            end else begin
               state_in = scs_pkg::ST_P2_STEP;
            end
         end
         scs_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = scs_pkg::ST_IDLE;
         end
         default: begin
            state_in = scs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/split_count_selector.sv */
// Top level of the split count selector: CSR block, sequencer and datapath.
// Depends on scs_pkg, scs_ctrl, scs_datapath (and scs_divider below it).
// Usage:
//  - Request: drive req_work_blocks and req_column_blocks and raise start; the
//    beat is taken at the edge where start is high and busy is low. busy then
//    stays high until the result has been shown.
//  - Result: rsp_split_count is valid for exactly one cycle, flagged by
//    rsp_strobe. The receiver cannot stall; sample it in that cycle.
//  - Configuration: APB-style, compute_units at byte 0x0, split_limit at 0x4
//    (byte offset bits ignored). Write only while busy is low.
// Sequence (accept edge to strobe):
//  - early out (work fills the units, no work, or an empty scan range): straight
//    from the check state to the strobe. Otherwise two passes over s = 1..L, L =
//    min(split_limit, compute_units, column_blocks, 128); the second pass stops
//    at the first good split count. Each first-pass count steps, launches the
//    column divider and waits for it; each second-pass count reads the
//    eligibility store, multiplies and checks. One item at a time; the next one
//    may start the cycle after the strobe.
// Reset: synchronous, returns to idle and loads compute_units = 128 and
// split_limit = 128; an item in flight is dropped with no result.

module split_count_selector (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  scs_pkg::work_type   req_work_blocks,
   input  scs_pkg::cols_type   req_column_blocks,
   output logic                rsp_strobe,
   output scs_pkg::split_type  rsp_split_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  scs_pkg::addr_type   paddr,
   input  scs_pkg::word_type   pwdata,
   output scs_pkg::word_type   prdata,
   output logic                pready
);

   scs_pkg::cu_type     cu_ff;
   scs_pkg::limit_type  limit_ff;
   scs_pkg::reg_index_type reg_idx;
   logic                csr_write;
   scs_pkg::cmd_type    cmd;
   scs_pkg::status_type status;

   // CSR decode: the register index is the word address bit
   assign reg_idx   = scs_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cu_ff    <= scs_pkg::CU_RESET;
         limit_ff <= scs_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         case (reg_idx)
            scs_pkg::REG_COMPUTE_UNITS: cu_ff    <= pwdata[scs_pkg::CU_W-1:0];
            scs_pkg::REG_SPLIT_LIMIT:   limit_ff <= pwdata[scs_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back: zero-extend the selected register
   always_comb begin
      case (reg_idx)
         scs_pkg::REG_COMPUTE_UNITS: prdata = scs_pkg::word_type'(cu_ff);
         scs_pkg::REG_SPLIT_LIMIT:   prdata = scs_pkg::word_type'(limit_ff);
         default:                    prdata = '0;
      endcase
   end

   // sequencer: owns busy and the result strobe
   scs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: holds operands, running counts, best ratio and the result
   scs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_work_blocks   (req_work_blocks),
      .req_column_blocks (req_column_blocks),
      .cfg_compute_units (cu_ff),
      .cfg_split_limit   (limit_ff),
      .split_count       (rsp_split_count)
   );

endmodule

/* rtl/scs_checker.sv */
// Port-level checks for split_count_selector, attached with a bind below.
// Depends on scs_pkg for the split count bound.

module scs_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input scs_pkg::split_type rsp_split_count
);

   // an accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a result is a single-cycle strobe
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // the result is shown while the block still reports busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // the chosen count stays within the scan range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_split_count != '0) &&
                     (rsp_split_count <= scs_pkg::split_type'(scs_pkg::SPLIT_CAP)))
      else $error("split count out of range");

   // reset clears the handshake outputs
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind split_count_selector scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_split_count (rsp_split_count)
);

/* sim/split_count_selector_checker.sv */
// Checker for the split count selector: watches the request, result and CSR ports.
// Predicts each split count, compares results in order and counts failures.
// Depends on scs_pkg only.
`timescale 1ns / 1ps

module split_count_selector_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  scs_pkg::work_type   req_work_blocks,
   input  scs_pkg::cols_type   req_column_blocks,
   input  logic                rsp_strobe,
   input  scs_pkg::split_type  rsp_split_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  scs_pkg::addr_type   paddr,
   input  scs_pkg::word_type   pwdata,
   input  scs_pkg::word_type   prdata,
   input  logic                pready,
   output int unsigned         fail_count,
   output int unsigned         outstanding
);

   scs_pkg::cu_type      units_reg;
   scs_pkg::limit_type   limit_reg;
   scs_pkg::split_type   split_counts_due[$];
   int unsigned          mismatches = 0;

   assign fail_count = mismatches;

   // s = 1 always counts; otherwise only if it changes the per-split column count
   function automatic bit split_useful(longint unsigned cols, longint unsigned s);
      return (s == 1) || ((cols + s - 1) / s != (cols + s - 2) / (s - 1));
   endfunction

   // efficiency n/(u*k) compared as n/k by cross multiplication
   function automatic scs_pkg::split_type pick_splits(scs_pkg::work_type work,
                                                      scs_pkg::cols_type cols,
                                                      scs_pkg::cu_type units,
                                                      scs_pkg::limit_type limit);
      longint unsigned w, c, u, lim, n, k, best_n, best_k;
      w = work;
      c = cols;
      u = units;
      if (5 * w >= 4 * u) return scs_pkg::split_type'(1);
      if (w == 0) return scs_pkg::split_type'(1);
      lim = limit;
      if (u < lim) lim = u;
      if (c < lim) lim = c;
      if (scs_pkg::SPLIT_CAP < lim) lim = scs_pkg::SPLIT_CAP;
      best_n = 0;
      best_k = 1;
      for (longint unsigned s = 1; s <= lim; s++) begin
         if (split_useful(c, s)) begin
            n = w * s;
            k = (n + u - 1) / u;
            if (n * best_k > best_n * k) begin
               best_n = n;
               best_k = k;
            end
         end
      end
      for (longint unsigned s = 1; s <= lim; s++) begin
         if (split_useful(c, s)) begin
            n = w * s;
            k = (n + u - 1) / u;
            if (20 * n * best_k >= 17 * best_n * k) return scs_pkg::split_type'(s);
         end
      end
      return scs_pkg::split_type'(1);
   endfunction

   always @(posedge clock) begin
      scs_pkg::split_type due;
      scs_pkg::word_type  held;
      if (reset) begin
         units_reg = scs_pkg::CU_RESET;
         limit_reg = scs_pkg::LIMIT_RESET;
         split_counts_due.delete();
      end else begin
         // retire the oldest expectation first, then take the new beat
         if (rsp_strobe) begin
            if (split_counts_due.size() == 0) begin
               $error("split_count: expected none, actual %0d", rsp_split_count);
               mismatches++;
            end else begin
               due = split_counts_due.pop_front();
               if (rsp_split_count !== due) begin
                  $error("split_count: expected %0d, actual %0d", due, rsp_split_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            split_counts_due = {split_counts_due,
                                pick_splits(req_work_blocks, req_column_blocks,
                                            units_reg, limit_reg)};
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (scs_pkg::reg_index_type'(paddr[2]))
                  scs_pkg::REG_COMPUTE_UNITS: units_reg = scs_pkg::cu_type'(pwdata);
                  scs_pkg::REG_SPLIT_LIMIT:   limit_reg = scs_pkg::limit_type'(pwdata);
                  default: ;
               endcase
            end else begin
               held = (scs_pkg::reg_index_type'(paddr[2]) == scs_pkg::REG_COMPUTE_UNITS) ?
                      scs_pkg::word_type'(units_reg) : scs_pkg::word_type'(limit_reg);
               if (prdata !== held) begin
                  $error("prdata: expected %0h, actual %0h", held, prdata);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= split_counts_due.size();
   end

endmodule

/* sim/split_count_selector_tb.sv */
// Testbench top for the split count selector: clock, reset, stimulus and verdict.
// Depends on scs_pkg, split_count_selector and split_count_selector_checker.
`timescale 1ns / 1ps

module split_count_selector_tb;

   // Watchdog bound on the quiet stretch with no beat at all; it must exceed the longest item.
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 250;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   scs_pkg::work_type   req_work_blocks = '0;
   scs_pkg::cols_type   req_column_blocks = '0;
   logic                rsp_strobe;
   scs_pkg::split_type  rsp_split_count;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   scs_pkg::addr_type   paddr = '0;
   scs_pkg::word_type   pwdata = '0;
   scs_pkg::word_type   prdata;
   logic                pready;
   int unsigned         fail_count;
   int unsigned         outstanding;
   int                  quiet_cycles = 0;

   // Mirror of the compute_units value last written, used to shape the random requests.
   int unsigned units_now = 128;

   split_count_selector u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_work_blocks   (req_work_blocks),
      .req_column_blocks (req_column_blocks),
      .rsp_strobe        (rsp_strobe),
      .rsp_split_count   (rsp_split_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   split_count_selector_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_work_blocks   (req_work_blocks),
      .req_column_blocks (req_column_blocks),
      .rsp_strobe        (rsp_strobe),
      .rsp_split_count   (rsp_split_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: any accepted request or result restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // One APB transfer: setup cycle, then access until pready. Leave psel up so
   // a following transfer can start its setup right away; csr_release drops it.
   task automatic csr_access(input logic is_write, input scs_pkg::reg_index_type idx,
                             input scs_pkg::word_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= scs_pkg::addr_type'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Drop start and hold until the last predicted split count has come back
   // and the block is idle again.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   // Reprogram both registers with junk in the unused upper bits, then read
   // them back. Only legal with the block idle, so drain first.
   task automatic set_config(input int unsigned units, input int unsigned limit);
      drain_results();
      csr_access(1'b1, scs_pkg::REG_COMPUTE_UNITS,
                 (scs_pkg::word_type'($urandom) & ~32'h7FF) | units);
      csr_access(1'b1, scs_pkg::REG_SPLIT_LIMIT,
                 (scs_pkg::word_type'($urandom) & ~32'hFF) | limit);
      csr_access(1'b0, scs_pkg::REG_COMPUTE_UNITS, '0);
      csr_access(1'b0, scs_pkg::REG_SPLIT_LIMIT, '0);
      csr_release();
      units_now = units & 32'h7FF;
   endtask

   // Offer one beat, idling first with the given odds per cycle; start stays
   // high after acceptance so back-to-back beats need no extra drive.
   task automatic send_item(input scs_pkg::work_type work, input scs_pkg::cols_type cols,
                            input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_work_blocks   <= work;
      req_column_blocks <= cols;
      start             <= 1'b1;
      do @(posedge clock); while (!(start && !busy));
   endtask

   initial begin
      int unsigned        idle_pct;
      int unsigned        pick;
      scs_pkg::work_type  work;
      scs_pkg::cols_type  cols;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset configuration first (128 units, limit 128).
      send_item(24'd0, 13'd1, 0);             // no work at all
      send_item(24'hFFFFFF, 13'h1FFF, 0);     // all ones, work fills the units
      send_item(24'd102, 13'd128, 0);         // last work value on the scan path
      send_item(24'd103, 13'd128, 0);         // first one that fills
      send_item(24'd10, 13'd0, 0);            // empty column range
      send_item(24'd1, 13'd4096, 0);
      send_item(24'd1, 13'd1, 0);
      send_item(24'd7, 13'd100, 0);
      send_item(24'd37, 13'd5, 0);
      // no compute units: the fill test always holds
      set_config(0, 128);
      send_item(24'd0, 13'd5, 0);
      send_item(24'hFFFFFF, 13'd1, 0);
      // widest register values; split limit above the scan cap
      set_config(2047, 255);
      send_item(24'd1000, 13'h1FFF, 0);
      send_item(24'd1, 13'd300, 0);
      send_item(24'd1637, 13'd200, 0);
      send_item(24'd1638, 13'd200, 0);
      // zero split limit: nothing to scan
      set_config(1024, 0);
      send_item(24'd5, 13'd50, 0);
      // efficiency ties: with work 2, s=2 and s=4 both give full waves
      set_config(4, 128);
      send_item(24'd2, 13'd8, 0);
      send_item(24'd3, 13'd8, 0);
      // smallest nonzero settings
      set_config(1, 1);
      send_item(24'd0, 13'd1, 0);
      send_item(24'd1, 13'd1, 0);
      set_config(1024, 128);
      send_item(24'd300, 13'd4096, 0);

      // Random phases: sender idles 14%, then 61%, then never.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(128, 128);
            1: set_config($urandom_range(2, 64), $urandom_range(1, 128));
            2: set_config(1024, 255);
            3: set_config($urandom_range(129, 2047), $urandom_range(0, 255));
            4: set_config($urandom_range(1, 2047), $urandom_range(0, 255));
            default: set_config($urandom_range(1, 8), 128);
         endcase
         idle_pct = (p < 2) ? 14 : (p < 4) ? 61 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Keep most requests on the scan path, where the real work is.
            pick = $urandom_range(99);
            if (units_now >= 2 && pick < 75)
               work = scs_pkg::work_type'($urandom_range(0, (4 * units_now - 1) / 5));
            else if (pick < 85)
               work = scs_pkg::work_type'((4 * units_now + 4) / 5 + $urandom_range(0, 3));
            else
               work = scs_pkg::work_type'($urandom);
            // Mostly short column ranges; a few full-width ones run the long scan.
            pick = $urandom_range(99);
            if (pick < 85)
               cols = scs_pkg::cols_type'($urandom_range(1, 32));
            else if (pick < 97)
               cols = scs_pkg::cols_type'($urandom);
            else
               cols = scs_pkg::cols_type'($urandom_range(0, 1));
            send_item(work, cols, idle_pct);
            // Now and then hold off until everything is back.
            if ($urandom_range(49) == 0) drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* split_count_selector.f */
rtl/scs_pkg.sv
rtl/scs_divider.sv
rtl/scs_datapath.sv
rtl/scs_ctrl.sv
rtl/split_count_selector.sv
rtl/scs_checker.sv
sim/split_count_selector_checker.sv
sim/split_count_selector_tb.sv
